@@ rtl/yhp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yhp_pkg
// Types and constants shared by the yaw hold proportional controller.
// ----------------------------------------------------------------------------
package yhp_pkg;

    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_RUN     = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam logic [23:0] SETTLE_RESET = 24'd1000000;
    localparam logic [8:0]  FULL_CIRCLE  = 9'd360;
    localparam logic [7:0]  SERVO_CENTER = 8'd90;
    localparam logic [7:0]  SERVO_MAX    = 8'd180;

    localparam logic signed [9:0] ERR_HALF_TURN = 10'sd180;
    localparam logic signed [9:0] ERR_FULL_TURN = 10'sd360;

    typedef struct packed {
        logic [23:0] settle_count;
        logic        ref_captured;
        logic [8:0]  ref_heading;
        logic [7:0]  servo_position;
    } yhp_state_t;

    typedef struct packed {
        logic [7:0]        servo_angle;
        logic [8:0]        reference_heading;
        logic              reference_valid;
        logic signed [8:0] control_error;
    } yhp_result_t;

endpackage

@@ rtl/yhp_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yhp_step
// Combinational update of controller state and result for one item.
// ----------------------------------------------------------------------------
module yhp_step
    import yhp_pkg::*;
(
    input  yhp_state_t  state_cur,
    input  logic [23:0] settle_ticks,
    input  logic [1:0]  cmd,
    input  logic [8:0]  heading,
    output yhp_state_t  state_next,
    output yhp_result_t result
);

    logic [8:0]        hd_fix;
    logic signed [9:0] err_raw;
    logic signed [9:0] err_wrap;
    logic signed [9:0] err_half;
    logic signed [9:0] pos_sum;
    logic [7:0]        pos_sat;
    logic signed [8:0] cerr;

    assign hd_fix  = (heading >= FULL_CIRCLE) ? heading - FULL_CIRCLE : heading;
    assign err_raw = $signed({1'b0, hd_fix}) - $signed({1'b0, state_cur.ref_heading});

    // shorter way round the circle
    always_comb begin
        if (err_raw > ERR_HALF_TURN) begin
            err_wrap = err_raw - ERR_FULL_TURN;
        end else if (err_raw < -ERR_HALF_TURN) begin
            err_wrap = err_raw + ERR_FULL_TURN;
        end else begin
            err_wrap = err_raw;
        end
    end

    // halve, truncating toward zero
    assign err_half = (err_wrap + $signed({9'd0, err_wrap[9]})) >>> 1;
    assign pos_sum  = $signed({2'b00, state_cur.servo_position}) + err_half;

    always_comb begin
        if (pos_sum < 10'sd0) begin
            pos_sat = 8'd0;
        end else if (pos_sum > $signed({2'b00, SERVO_MAX})) begin
            pos_sat = SERVO_MAX;
        end else begin
            pos_sat = pos_sum[7:0];
        end
    end

    always_comb begin
        state_next = state_cur;
        cerr       = 9'sd0;
        case (cmd)
            CMD_TICK: begin
                if (state_cur.settle_count != 24'd0) begin
                    state_next.settle_count = state_cur.settle_count - 24'd1;
                end
            end
            CMD_RESTART: begin
                state_next.settle_count = settle_ticks;
                state_next.ref_captured = 1'b0;
            end
            CMD_RUN: begin
                if (!state_cur.ref_captured) begin
                    state_next.servo_position = SERVO_CENTER;
                    if (state_cur.settle_count == 24'd0) begin
                        state_next.ref_heading  = hd_fix;
                        state_next.ref_captured = 1'b1;
                    end
                end else begin
                    state_next.servo_position = pos_sat;
                    cerr                      = err_wrap[8:0];
                end
            end
            default: begin
                state_next = state_cur;
            end
        endcase
    end

    assign result.servo_angle       = state_next.servo_position;
    assign result.reference_heading = state_next.ref_heading;
    assign result.reference_valid   = state_next.ref_captured;
    assign result.control_error     = cerr;

endmodule

@@ rtl/yaw_hold_p_controller_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yaw_hold_p_controller_unit
// Heading-hold proportional controller: settle timer, reference capture,
// wrapped error and saturated servo angle, one result per item.
// ----------------------------------------------------------------------------
// an item is taken into the input register when accepted; its result is
// written to the result register when the result channel is free
// throughput: one item per cycle while m_ready does not hold the output;
// the state update runs through the step logic between the two registers
// reset (aresetn low, synchronous): settle_ticks and the timer load 1000000,
// reference dropped, servo at 0, both registers empty
module yaw_hold_p_controller_unit
    import yhp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [8:0]  s_heading,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_servo_angle,
    output logic [8:0]  m_reference_heading,
    output logic        m_reference_valid,
    output logic [8:0]  m_control_error
);

    logic [23:0] settle_ticks_reg;
    logic        in_valid_reg;
    logic [1:0]  cmd_reg;
    logic [8:0]  heading_reg;
    yhp_state_t  state_reg;
    yhp_state_t  state_next;
    yhp_result_t result_next;
    yhp_result_t result_reg;
    logic        out_valid_reg;
    logic        out_free;
    logic        advance;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_ready;
    assign advance   = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_ticks_reg <= SETTLE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            settle_ticks_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg     <= s_cmd;
            heading_reg <= s_heading;
        end
    end

    yhp_step u_step (
        .state_cur    (state_reg),
        .settle_ticks (settle_ticks_reg),
        .cmd          (cmd_reg),
        .heading      (heading_reg),
        .state_next   (state_next),
        .result       (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.settle_count   <= SETTLE_RESET;
            state_reg.ref_captured   <= 1'b0;
            state_reg.ref_heading    <= 9'd0;
            state_reg.servo_position <= 8'd0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_servo_angle       = result_reg.servo_angle;
    assign m_reference_heading = result_reg.reference_heading;
    assign m_reference_valid   = result_reg.reference_valid;
    assign m_control_error     = result_reg.control_error;

endmodule

@@ rtl/yhp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yhp_checker
// Port-level checks on the result channel of the yaw hold controller.
// ----------------------------------------------------------------------------
module yhp_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_servo_angle,
    input logic [8:0] m_reference_heading,
    input logic       m_reference_valid,
    input logic [8:0] m_control_error
);

    // a stalled item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_servo_angle)
            && $stable(m_reference_heading) && $stable(m_reference_valid)
            && $stable(m_control_error))
        else $error("result item changed while stalled");

    a_servo_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_servo_angle <= 8'd180)
        else $error("servo angle above 180");

    // no correction without a held reference
    a_err_needs_ref: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_reference_valid |-> m_control_error == 9'd0)
        else $error("control error without reference");

    a_ref_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_reference_heading <= 9'd359)
        else $error("reference heading out of range");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind yaw_hold_p_controller_unit yhp_checker u_yhp_checker (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_servo_angle       (m_servo_angle),
    .m_reference_heading (m_reference_heading),
    .m_reference_valid   (m_reference_valid),
    .m_control_error     (m_control_error)
);
